// File: src/sblb_pkg.sv
// Shared sizes, codes and control types for the S-box linear bias checker.
package sblb_pkg;

  localparam int INDEX_BITS = 4;
  localparam int VALUE_BITS = 4;

  localparam int NUM_POS    = 1 << INDEX_BITS;
  localparam int HALF       = NUM_POS / 2;
  localparam int NUM_SCORES = (NUM_POS - 1) * VALUE_BITS;

  localparam int SCORE_W = INDEX_BITS + 1;
  localparam int ADDR_W  = (NUM_SCORES > 1) ? $clog2(NUM_SCORES) : 1;
  localparam int CNT_W   = $clog2(NUM_SCORES + 1);
  localparam int BIT_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int CMP_W   = INDEX_BITS + 7;

  localparam int THR_W      = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_THRESHOLD = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_UPPER = 2'd1,
    STATUS_LOWER = 2'd2,
    STATUS_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic load_out;
  } sblb_cmd_t;

  typedef struct packed {
    logic issue_done;
    logic pipe_busy;
  } sblb_stat_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  max_score;
    logic [4:0]  min_score;
    logic [4:0]  filled_count;
  } sblb_result_t;

endpackage

// File: src/sblb_in_if.sv
// Request channel carrying one S-box entry (position and value).
interface sblb_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] entry_index;
  logic [3:0] entry_value;

  modport source (output valid, entry_index, entry_value, input ready);
  modport sink (input valid, entry_index, entry_value, output ready);
endinterface

// File: src/sblb_out_if.sv
// Result channel carrying status and score extremes for each request.
interface sblb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] max_score;
  logic [4:0] min_score;
  logic [4:0] filled_count;

  modport source (output valid, status, max_score, min_score, filled_count, input ready);
  modport sink (input valid, status, max_score, min_score, filled_count, output ready);
endinterface

// File: src/sblb_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module sblb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: src/sblb_ctrl.sv
// Controller state machine: accept, sweep the score table, deliver result.
module sblb_ctrl
  import sblb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  sblb_stat_t st,
  output sblb_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_DONE  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.start    = 1'b0;
    cmd.issue    = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.issue = !st.issue_done;
        if (st.issue_done && !st.pipe_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: src/sblb_datapath.sv
// Datapath: entry bookkeeping, score RAM sweep, extremes and status.
module sblb_datapath
  import sblb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  sblb_cmd_t             cmd,
  output sblb_stat_t            st,
  input  logic [3:0]            entry_index,
  input  logic [3:0]            entry_value,
  input  logic [THR_W-1:0]      threshold,
  output sblb_result_t          result
);

  logic [INDEX_BITS-1:0] pos_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  new_r;
  logic [NUM_POS-1:0]    seen_r;
  logic [INDEX_BITS:0]   assigned_r;

  logic [CNT_W-1:0]      rd_addr_r;
  logic [INDEX_BITS-1:0] rd_a_r;
  logic [BIT_W-1:0]      rd_b_r;

  logic                  wr_valid_r;
  logic [ADDR_W-1:0]     wr_addr_r;
  logic [INDEX_BITS-1:0] wr_a_r;
  logic [BIT_W-1:0]      wr_b_r;
  logic                  wr_vld_r;

  logic [NUM_SCORES-1:0] vld_r;
  logic [SCORE_W-1:0]    max_r, min_r;
  sblb_result_t          result_r;

  logic [SCORE_W-1:0]    rdata;
  logic [SCORE_W-1:0]    old_score;
  logic [SCORE_W-1:0]    new_score;
  logic                  agree;
  logic [ADDR_W-1:0]     rd_addr;
  status_t               status_nxt;

  assign rd_addr   = rd_addr_r[ADDR_W-1:0];
  assign old_score = wr_vld_r ? rdata : '0;
  assign agree     = new_r && ((^(pos_r & wr_a_r)) == val_r[wr_b_r]);
  assign new_score = old_score + SCORE_W'(agree);

  sblb_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (NUM_SCORES)
  ) u_score_ram (
    .clk     (clk),
    .we      (wr_valid_r),
    .waddr   (wr_addr_r),
    .wdata   (new_score),
    .raddr   (rd_addr),
    .rdata_r (rdata)
  );

  // Entry state and the read side of the sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      assigned_r <= '0;
      new_r      <= 1'b0;
      rd_addr_r  <= CNT_W'(NUM_SCORES);
      wr_valid_r <= 1'b0;
      vld_r      <= '0;
    end else begin
      wr_valid_r <= cmd.issue;
      if (cmd.start) begin
        new_r     <= !seen_r[entry_index[INDEX_BITS-1:0]];
        rd_addr_r <= '0;
        if (!seen_r[entry_index[INDEX_BITS-1:0]]) begin
          seen_r[entry_index[INDEX_BITS-1:0]] <= 1'b1;
          assigned_r <= assigned_r + 1'b1;
        end
      end else if (cmd.issue) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
      if (wr_valid_r) begin
        vld_r[wr_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pos_r  <= entry_index[INDEX_BITS-1:0];
      val_r  <= entry_value[VALUE_BITS-1:0];
      rd_a_r <= INDEX_BITS'(1);
      rd_b_r <= '0;
      max_r  <= '0;
      min_r  <= SCORE_W'(NUM_POS);
    end else begin
      if (cmd.issue) begin
        if (rd_b_r == BIT_W'(VALUE_BITS - 1)) begin
          rd_b_r <= '0;
          rd_a_r <= rd_a_r + 1'b1;
        end else begin
          rd_b_r <= rd_b_r + 1'b1;
        end
      end
      if (wr_valid_r) begin
        if (new_score > max_r) begin
          max_r <= new_score;
        end
        if (new_score < min_r) begin
          min_r <= new_score;
        end
      end
    end
    if (cmd.issue) begin
      wr_addr_r <= rd_addr;
      wr_a_r    <= rd_a_r;
      wr_b_r    <= rd_b_r;
      wr_vld_r  <= vld_r[rd_addr];
    end
    if (cmd.load_out) begin
      result_r.status       <= status_nxt;
      result_r.max_score    <= 5'(max_r);
      result_r.min_score    <= 5'(min_r);
      result_r.filled_count <= 5'(assigned_r);
    end
  end

  // lower test rearranged: min + thr + NUM_POS < half + assigned
  always_comb begin
    priority if (CMP_W'(max_r) > CMP_W'(HALF) + CMP_W'(threshold)) begin
      status_nxt = STATUS_UPPER;
    end else if (CMP_W'(min_r) + CMP_W'(threshold) + CMP_W'(NUM_POS)
                 < CMP_W'(HALF) + CMP_W'(assigned_r)) begin
      status_nxt = STATUS_LOWER;
    end else if (assigned_r >= (INDEX_BITS + 1)'(NUM_POS)) begin
      status_nxt = STATUS_FULL;
    end else begin
      status_nxt = STATUS_OK;
    end
  end

  assign st.issue_done = (rd_addr_r == CNT_W'(NUM_SCORES));
  assign st.pipe_busy  = wr_valid_r;
  assign result        = result_r;

  a_wr_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_valid_r |-> (CNT_W'(wr_addr_r) < CNT_W'(NUM_SCORES)))
    else $error("score write address out of range");

  a_score_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_valid_r |-> (SCORE_W'(new_score) <= SCORE_W'(assigned_r)))
    else $error("score exceeds number of assigned entries");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (min_r <= max_r))
    else $error("min score above max score at result load");

endmodule

// File: src/sbox_linear_bias_checker.sv
// Top level of the S-box linear bias checker: APB register, controller, datapath.
// Each request passes through the accept in the idle state, 60 reads of the score RAM
// issued back to back through its single read port with the incremented score written
// back in the cycle after each read, a drain of that pipeline, and the load of the result
// register. A result may wait in the output register while the next request is already
// accepted. The score table needs no clearing after reset; per-entry valid bits make
// unwritten scores read as zero.
// The threshold register sits at byte address 0 and should be written only while idle.
module sbox_linear_bias_checker
  import sblb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  sblb_in_if.sink               in_chan,
  sblb_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [THR_W-1:0] threshold_r;
  logic             thr_sel;
  sblb_cmd_t        cmd;
  sblb_stat_t       st;
  sblb_result_t     result;

  assign thr_sel = (paddr[CFG_ADDR_W-1] == REG_THRESHOLD);
  assign pready  = 1'b1;
  assign prdata  = thr_sel ? CFG_DATA_W'(threshold_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
    end else if (psel && penable && pwrite && thr_sel) begin
      threshold_r <= pwdata[THR_W-1:0];
    end
  end

  sblb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .st        (st),
    .cmd       (cmd)
  );

  sblb_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .entry_index (in_chan.entry_index),
    .entry_value (in_chan.entry_value),
    .threshold   (threshold_r),
    .result      (result)
  );

  assign out_chan.status       = result.status;
  assign out_chan.max_score    = result.max_score;
  assign out_chan.min_score    = result.min_score;
  assign out_chan.filled_count = result.filled_count;

endmodule

// File: dv/tb_sbox_linear_bias_checker.sv
// Testbench for the S-box linear bias checker: APB threshold setup, directed and random entries, scoreboard.
`timescale 1ns / 1ps

module tb_sbox_linear_bias_checker
  import sblb_pkg::*;
();

  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 70;

  typedef struct packed {
    logic [3:0] pos;
    logic [3:0] val;
  } sbox_entry_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  sblb_in_if  in_chan ();
  sblb_out_if out_chan ();

  sbox_linear_bias_checker i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // predictor state
  logic [4:0] agree_cnt [NUM_SCORES];
  logic       pos_taken [NUM_POS];
  logic [4:0] filled_total;
  logic [4:0] thr_model;

  sbox_entry_t  entry_queue[$];
  sblb_result_t expected_verdicts[$];
  int           entries_sent;
  int           entries_taken;
  int           err_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  logic         in_taken;
  logic         hold_out;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  function automatic sblb_result_t score_entry(logic [3:0] pos, logic [3:0] val);
    int           hi;
    int           lo;
    int           upper;
    int           lower;
    sblb_result_t r;
    if (!pos_taken[pos]) begin
      pos_taken[pos] = 1'b1;
      filled_total   = filled_total + 5'd1;
      for (int a = 1; a < NUM_POS; a++) begin
        for (int b = 0; b < VALUE_BITS; b++) begin
          if ((^(pos & INDEX_BITS'(a))) == val[b]) begin
            agree_cnt[(a - 1) * VALUE_BITS + b] = agree_cnt[(a - 1) * VALUE_BITS + b] + 5'd1;
          end
        end
      end
    end
    hi = 0;
    lo = NUM_POS;
    for (int k = 0; k < NUM_SCORES; k++) begin
      if (int'(agree_cnt[k]) > hi) hi = int'(agree_cnt[k]);
      if (int'(agree_cnt[k]) < lo) lo = int'(agree_cnt[k]);
    end
    upper = HALF + int'(thr_model);
    lower = HALF - int'(thr_model) - (NUM_POS - int'(filled_total));
    if (hi > upper) begin
      r.status = STATUS_UPPER;
    end else if (lo < lower) begin
      r.status = STATUS_LOWER;
    end else if (int'(filled_total) >= NUM_POS) begin
      r.status = STATUS_FULL;
    end else begin
      r.status = STATUS_OK;
    end
    r.max_score    = hi[4:0];
    r.min_score    = lo[4:0];
    r.filled_count = filled_total;
    return r;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      if (entry_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sbox_entry_t e;
        e = entry_queue.pop_front();
        in_chan.valid       <= 1'b1;
        in_chan.entry_index <= e.pos;
        in_chan.entry_value <= e.val;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= !hold_out && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off
  always begin
    wait (hold_out);
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out = 1'b0;
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: status %0d", out_chan.status);
          err_count++;
        end else begin
          sblb_result_t exp_r;
          exp_r = expected_verdicts.pop_front();
          if (out_chan.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_chan.status);
            err_count++;
          end
          if (out_chan.max_score !== exp_r.max_score) begin
            $error("max_score: expected %0d, got %0d", exp_r.max_score, out_chan.max_score);
            err_count++;
          end
          if (out_chan.min_score !== exp_r.min_score) begin
            $error("min_score: expected %0d, got %0d", exp_r.min_score, out_chan.min_score);
            err_count++;
          end
          if (out_chan.filled_count !== exp_r.filled_count) begin
            $error("filled_count: expected %0d, got %0d", exp_r.filled_count,
                   out_chan.filled_count);
            err_count++;
          end
        end
      end
      in_taken <= in_chan.valid && in_chan.ready;
      if (in_chan.valid && in_chan.ready) begin
        expected_verdicts.push_back(score_entry(in_chan.entry_index, in_chan.entry_value));
        entries_taken++;
      end
    end
  end

  task automatic push_entry(logic [3:0] pos, logic [3:0] val);
    entry_queue.push_back('{pos: pos, val: val});
    entries_sent++;
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      push_entry(4'($urandom), 4'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (entries_taken != entries_sent || expected_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [4:0] thr);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * int'(REG_THRESHOLD));
    pwdata  <= CFG_DATA_W'(thr);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    thr_model = thr;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== CFG_DATA_W'(thr_model)) begin
      $error("threshold: expected %0d, got %0d", thr_model, prdata);
      err_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_chan.valid       = 1'b0;
    in_chan.entry_index = '0;
    in_chan.entry_value = '0;
    out_chan.ready      = 1'b0;
    in_taken            = 1'b0;
    hold_out            = 1'b0;
    entries_sent        = 0;
    entries_taken       = 0;
    err_count           = 0;
    filled_total        = '0;
    thr_model           = '0;
    set_idling(0, 0);
    for (int k = 0; k < NUM_SCORES; k++) agree_cnt[k] = '0;
    for (int p = 0; p < NUM_POS; p++) pos_taken[p] = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: extremes, repeats, failure then more updates
    write_threshold(5'd0);
    push_entry(4'd0, 4'd0);
    push_entry(4'd0, 4'd15);
    push_entry(4'd15, 4'd15);
    push_entry(4'd15, 4'd0);
    push_entry(4'd1, 4'd10);
    push_entry(4'd2, 4'd5);
    push_entry(4'd4, 4'd3);
    push_entry(4'd8, 4'd12);
    push_entry(4'd7, 4'd9);
    push_entry(4'd14, 4'd6);
    push_entry(4'd11, 4'd1);
    push_entry(4'd5, 4'd14);
    push_entry(4'd5, 4'd2);
    wait_drained();

    write_threshold(5'd31);
    push_entry(4'd1, 4'd0);
    push_entry(4'd9, 4'd7);
    wait_drained();

    write_threshold(5'd16);
    push_entry(4'd3, 4'd11);
    push_entry(4'd12, 4'd8);
    wait_drained();

    write_threshold(5'd2);
    push_entry(4'd6, 4'd4);
    push_entry(4'd10, 4'd13);
    push_entry(4'd13, 4'd15);
    push_entry(4'd13, 4'd0);
    wait_drained();

    // random phases
    write_threshold(5'($urandom_range(3)));
    set_idling(0, 0);
    push_random(150);
    wait_drained();

    write_threshold(5'd31);
    set_idling(83, 0);
    push_random(200);
    wait_drained();

    write_threshold(5'd16);
    set_idling(0, 83);
    push_random(200);
    wait_drained();

    write_threshold(5'($urandom_range(31)));
    set_idling(9, 9);
    @(posedge clk);
    hold_out = 1'b1;
    push_random(200);
    wait_drained();

    write_threshold(5'($urandom_range(8)));
    set_idling(0, 0);
    push_random(100);
    wait_drained();

    write_threshold(5'd0);
    set_idling(83, 83);
    push_random(100);
    wait_drained();

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
